@@ rtl/aef_pkg.sv @@
// ----------------------------------------------------------------------------
// aef_pkg: shared definitions for the allpass echo filter
// Widths, register indexes, delay limits and the Q1.15 rounding and
// saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package aef_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 16;
  localparam int FRAC_BITS   = GAIN_BITS - 1;
  localparam int MAX_DELAY   = 16384;
  localparam int MIN_DELAY   = 16;
  localparam int IDX_BITS    = $clog2(MAX_DELAY);
  localparam int LEN_BITS    = 15;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 1;

  // product and rounded-product widths
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
  localparam int RND_BITS  = PROD_BITS + 1 - FRAC_BITS;
  localparam int SUM_BITS  = RND_BITS + 1;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_GAIN = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_LENGTH  = 1'd1;

  localparam logic [LEN_BITS-1:0] DELAY_MIN = LEN_BITS'(MIN_DELAY);
  localparam logic [LEN_BITS-1:0] DELAY_MAX = LEN_BITS'(MAX_DELAY);

  // write port into the delay store
  typedef struct packed {
    logic                   en;
    logic [IDX_BITS-1:0]    addr;
    logic [SAMPLE_BITS-1:0] data;
  } wr_t;

  // round a Q.15 product to nearest, ties toward plus infinity
  function automatic logic signed [RND_BITS-1:0] round_q15(
    input logic signed [PROD_BITS-1:0] p
  );
    logic signed [PROD_BITS:0] biased;
    biased = {p[PROD_BITS-1], p} + (PROD_BITS+1)'(1 << (FRAC_BITS - 1));
    return biased[PROD_BITS:FRAC_BITS];
  endfunction

  // clamp to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] hi;
    logic signed [SAMPLE_BITS-1:0] lo;
    hi = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    lo = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    if (v > SUM_BITS'(hi)) begin
      return hi;
    end else if (v < SUM_BITS'(lo)) begin
      return lo;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

@@ rtl/aef_delay_line.sv @@
// ----------------------------------------------------------------------------
// aef_delay_line: circular delay store with running index
// Single-port-write, registered-read sample memory. The read index walks
// 0..len-1 and wraps; until the first wrap after reset or a length write,
// every entry read is forced to zero.
// ----------------------------------------------------------------------------
module aef_delay_line (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  len_we,
  input  logic [aef_pkg::LEN_BITS-1:0]          len_value,
  input  logic                                  rd_en,
  input  aef_pkg::wr_t                          wr,
  output logic signed [aef_pkg::SAMPLE_BITS-1:0] rd_data,
  output logic [aef_pkg::IDX_BITS-1:0]          rd_addr
);

  logic [aef_pkg::SAMPLE_BITS-1:0] mem [aef_pkg::MAX_DELAY];
  logic [aef_pkg::SAMPLE_BITS-1:0] mem_q;
  logic                            blank;
  logic [aef_pkg::IDX_BITS-1:0]    idx;
  logic                            wrapped;
  logic [aef_pkg::LEN_BITS-1:0]    len_eff;
  logic [aef_pkg::LEN_BITS-1:0]    len_clamped;
  logic [aef_pkg::LEN_BITS-1:0]    idx_inc;
  logic                            at_end;

  // clamp the programmed length into the supported range
  always_comb begin
    if (len_value < aef_pkg::DELAY_MIN) begin
      len_clamped = aef_pkg::DELAY_MIN;
    end else if (len_value > aef_pkg::DELAY_MAX) begin
      len_clamped = aef_pkg::DELAY_MAX;
    end else begin
      len_clamped = len_value;
    end
  end

  assign idx_inc = {1'b0, idx} + aef_pkg::LEN_BITS'(1);
  assign at_end  = (idx_inc >= len_eff);

  // index, wrap flag and length
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      wrapped <= 1'b0;
      len_eff <= aef_pkg::DELAY_MIN;
    end else if (len_we) begin
      idx     <= '0;
      wrapped <= 1'b0;
      len_eff <= len_clamped;
    end else if (rd_en) begin
      if (at_end) begin
        idx     <= '0;
        wrapped <= 1'b1;
      end else begin
        idx <= idx_inc[aef_pkg::IDX_BITS-1:0];
      end
    end
  end

  // memory write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read; holds while no item is taken
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q   <= mem[idx];
      rd_addr <= idx;
      blank   <= !wrapped;
    end
  end

  assign rd_data = blank ? '0 : $signed(mem_q);

endmodule

@@ rtl/allpass_echo_filter.sv @@
// ----------------------------------------------------------------------------
// allpass_echo_filter: Schroeder allpass echo over a circular delay store
// Pipeline: 5 register stages, the first loaded at the accept edge: memory
// read, feedback multiply, feedforward sum, output multiply, output.
// Throughput: one item per cycle while the output is not stalled; each stage
// moves on its own, so bubbles collapse and a stalled result does not block
// upstream stages behind a gap.
// Reset: gain 0, delay 16, index 0, store reads as zero; no clearing pass.
// ----------------------------------------------------------------------------
module allpass_echo_filter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [aef_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [aef_pkg::CFG_BITS-1:0]           cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [aef_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic                                   last_in_block,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [aef_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                   last_out
);

  logic signed [aef_pkg::GAIN_BITS-1:0] gain;
  logic                                 len_we;

  // stage valids and enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;
  logic accept;

  // stage 1
  logic signed [aef_pkg::SAMPLE_BITS-1:0] x1;
  logic                                   last1;
  logic signed [aef_pkg::SAMPLE_BITS-1:0] d1;
  logic [aef_pkg::IDX_BITS-1:0]           addr1;
  // stage 2
  logic signed [aef_pkg::PROD_BITS-1:0]   p2;
  logic signed [aef_pkg::SAMPLE_BITS-1:0] x2;
  logic signed [aef_pkg::SAMPLE_BITS-1:0] d2;
  logic [aef_pkg::IDX_BITS-1:0]           addr2;
  logic                                   last2;
  // stage 3
  logic signed [aef_pkg::SAMPLE_BITS-1:0] w3;
  logic signed [aef_pkg::SAMPLE_BITS-1:0] d3;
  logic                                   last3;
  logic signed [aef_pkg::SAMPLE_BITS-1:0] w_next;
  // stage 4
  logic signed [aef_pkg::PROD_BITS-1:0]   p4;
  logic signed [aef_pkg::SAMPLE_BITS-1:0] d4;
  logic                                   last4;
  logic signed [aef_pkg::SAMPLE_BITS-1:0] y_next;

  aef_pkg::wr_t wr;

  // configuration
  assign len_we = cfg_we && (cfg_index == aef_pkg::REG_DELAY_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
    end else if (cfg_we && (cfg_index == aef_pkg::REG_FEEDBACK_GAIN)) begin
      gain <= $signed(cfg_data[aef_pkg::GAIN_BITS-1:0]);
    end
  end

  // stage enables: a stage loads when empty or when its successor moves
  assign en5      = !v5 || !out_stall;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1: delay store read
  aef_delay_line u_delay (
    .clk       (clk),
    .rst       (rst),
    .len_we    (len_we),
    .len_value (cfg_data[aef_pkg::LEN_BITS-1:0]),
    .rd_en     (accept),
    .wr        (wr),
    .rd_data   (d1),
    .rd_addr   (addr1)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      x1    <= sample_in;
      last1 <= last_in_block;
    end
  end

  // stage 2: feedback product d*g
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      p2    <= d1 * gain;
      x2    <= x1;
      d2    <= d1;
      addr2 <= addr1;
      last2 <= last1;
    end
  end

  // stage 3: w = sat(round(d*g) + x), written back to the store
  assign w_next = aef_pkg::sat_sample(
    aef_pkg::SUM_BITS'(aef_pkg::round_q15(p2)) + aef_pkg::SUM_BITS'(x2));

  assign wr.en   = en3 && v2;
  assign wr.addr = addr2;
  assign wr.data = w_next;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      w3    <= w_next;
      d3    <= d2;
      last3 <= last2;
    end
  end

  // stage 4: output product g*w
  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      p4    <= w3 * gain;
      d4    <= d3;
      last4 <= last3;
    end
  end

  // stage 5: y = sat(d - round(g*w)), output register
  assign y_next = aef_pkg::sat_sample(
    aef_pkg::SUM_BITS'(d4) - aef_pkg::SUM_BITS'(aef_pkg::round_q15(p4)));

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      sample_out <= y_next;
      last_out   <= last4;
    end
  end

  assign out_valid = v5;

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for allpass_echo_filter
// A clocked driver feeds samples from a queue, and a clocked monitor checks each
// filtered sample against an allpass predictor that keeps its own delay store.
// The gain and delay length are changed between phases while the block is idle.
// Both sides idle and stall at random, except during one calm phase.
// ----------------------------------------------------------------------------
module testbench;
  import aef_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } audio_item_t;

  localparam int     QUIET_LIMIT  = 2000;
  localparam int     DRAIN_CYCLES = 20;
  localparam int     TARGET_ITEMS = 1650;
  localparam int     IDLE_PCT     = 13;
  localparam longint SAMPLE_HI    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO    = -SAMPLE_HI - 1;

  // DUT signals; the inputs are known from time zero
  logic                          clk           = 1'b0;
  logic                          rst           = 1'b1;
  logic                          cfg_we        = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index     = '0;
  logic [CFG_BITS-1:0]           cfg_data      = '0;
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample_in     = '0;
  logic                          last_in_block = 1'b0;
  logic                          out_valid;
  logic                          out_stall     = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          last_out;

  // bench state
  audio_item_t sample_q[$];
  audio_item_t filtered_q[$];
  audio_item_t next_item;
  audio_item_t want;
  bit          calm = 1'b0;
  int          fault_count = 0;
  int          quiet_cycles = 0;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] echo_mem [MAX_DELAY];
  int unsigned                   echo_pos;
  logic signed [GAIN_BITS-1:0]   gain_q15;
  logic [LEN_BITS-1:0]           delay_reg;

  allpass_echo_filter uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_in     (sample_in),
    .last_in_block (last_in_block),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .last_out      (last_out)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // allpass predictor
  // ---------------------------------------------------------------------------

  // Q.15 product rounded to nearest, ties toward plus infinity
  function automatic longint gain_product(longint a, longint g);
    return (a * g + 16384) >>> 15;
  endfunction

  function automatic longint clamp_sample(longint v);
    if (v > SAMPLE_HI) return SAMPLE_HI;
    if (v < SAMPLE_LO) return SAMPLE_LO;
    return v;
  endfunction

  function automatic int unsigned delay_span();
    int unsigned span;
    span = delay_reg;
    if (span < MIN_DELAY) span = MIN_DELAY;
    if (span > MAX_DELAY) span = MAX_DELAY;
    return span;
  endfunction

  function automatic void clear_echo();
    foreach (echo_mem[i]) echo_mem[i] = '0;
    echo_pos = 0;
  endfunction

  // one sample through the allpass section; queues the filtered sample
  function automatic void allpass_step(logic signed [SAMPLE_BITS-1:0] x, logic last);
    int unsigned span;
    longint      d;
    longint      w;
    longint      y;
    audio_item_t res;
    span = delay_span();
    if (echo_pos >= span) echo_pos = 0;
    d = echo_mem[echo_pos];
    w = clamp_sample(gain_product(d, gain_q15) + x);
    y = clamp_sample(d - gain_product(w, gain_q15));
    echo_mem[echo_pos] = w[SAMPLE_BITS-1:0];
    echo_pos++;
    if (echo_pos >= span) echo_pos = 0;
    res.sample = y[SAMPLE_BITS-1:0];
    res.last   = last;
    filtered_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued samples, idling at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        allpass_step(sample_in, last_in_block);
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_item = sample_q.pop_front();
          in_valid      <= 1'b1;
          sample_in     <= next_item.sample;
          last_in_block <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks filtered samples, stalls at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("unexpected result: sample %0d last %0b", sample_out, last_out);
          end
        end else begin
          want = filtered_q.pop_front();
          if (want.sample !== sample_out || want.last !== last_out) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                       want.sample, want.last, sample_out, last_out);
            end
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_HI[SAMPLE_BITS-1:0];
      1:       return SAMPLE_LO[SAMPLE_BITS-1:0];
      2:       return SAMPLE_BITS'($signed($urandom_range(0, 511)) - 256);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  task automatic push_item(longint s, logic last);
    audio_item_t it;
    it.sample = s[SAMPLE_BITS-1:0];
    it.last   = last;
    sample_q.push_back(it);
  endtask

  // register write at the next edge; the predictor follows at once since the
  // block is idle
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_FEEDBACK_GAIN) begin
      gain_q15 = data;
    end else begin
      delay_reg = data[LEN_BITS-1:0];
      clear_echo();
    end
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // checked mid-cycle so the driver's updates at the edge have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || filtered_q.size() != 0);
  endtask

  // new settings, then a run of random samples
  task automatic run_phase(logic [CFG_BITS-1:0] gain, logic [CFG_BITS-1:0] len,
                           bit new_len, int n, bit quiet);
    write_reg(REG_FEEDBACK_GAIN, gain);
    if (new_len) write_reg(REG_DELAY_LENGTH, len);
    end_writes();
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      push_item(pick_sample(), $urandom_range(0, 7) == 0);
    end
    wait_drained();
  endtask

  initial begin
    int total;
    int phase;
    int n;
    int unsigned len;

    gain_q15  = '0;
    delay_reg = DELAY_MIN;
    clear_echo();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero gain, shortest delay
    push_item(SAMPLE_HI, 1'b0);
    push_item(SAMPLE_LO, 1'b0);
    push_item(-1, 1'b0);
    push_item(64'sh2AAAAA, 1'b1);
    wait_drained();

    // near unity gain: full-scale alternation fills the store, two samples read it back
    write_reg(REG_FEEDBACK_GAIN, 16'sd32767);
    write_reg(REG_DELAY_LENGTH, CFG_BITS'(MIN_DELAY));
    end_writes();
    for (int i = 0; i < 16; i++) begin
      push_item((i % 2 == 0) ? SAMPLE_HI : SAMPLE_LO, i == 15);
    end
    push_item(0, 1'b0);
    push_item(1, 1'b1);
    wait_drained();

    // gain alone changes: store and index carry over
    write_reg(REG_FEEDBACK_GAIN, 16'h8000);
    end_writes();
    push_item(SAMPLE_HI, 1'b0);
    push_item(SAMPLE_LO, 1'b0);
    push_item(0, 1'b0);
    push_item(-1, 1'b1);
    wait_drained();

    // extreme settings: short, odd, longest and over-long delays
    run_phase(16'sd32767, 16'd0,     1'b1, 60, 1'b0);
    run_phase(16'h8000,   16'd15,    1'b1, 60, 1'b0);
    run_phase(16'd1,      16'd17,    1'b1, 80, 1'b0);
    run_phase(16'hFFFF,   16'd16384, 1'b1, 40, 1'b0);
    run_phase(16'sd24000, 16'd16385, 1'b1, 30, 1'b0);
    run_phase(-16'sd20000, 16'hFFFF, 1'b1, 30, 1'b0);
    total = 26 + 300;

    // random settings, mostly short delays so the echo feeds back
    phase = 0;
    while (total < TARGET_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(0, 32767);
      end else begin
        len = $urandom_range(0, 96);
      end
      if (phase == 2) begin
        n = 300;
      end else if (len > 1000) begin
        n = 40;
      end else begin
        n = $urandom_range(60, 160);
      end
      run_phase(CFG_BITS'($urandom()), {1'($urandom_range(0, 1)), LEN_BITS'(len)},
                $urandom_range(0, 3) != 0, n, phase == 2);
      total += n;
      phase++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && filtered_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/aef_pkg.sv
rtl/aef_delay_line.sv
rtl/allpass_echo_filter.sv
test/testbench.sv
